/* rtl/pidpos_pkg.sv */
// Package for the stream position PID controller.
// Holds configuration register indexes, field widths and reset values.
// No dependencies.
package pidpos_pkg;

    localparam int GAIN_WIDTH       = 24;
    localparam int LIMIT_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH   = 24;

    // Operands are bounded to +-(2^36 - 1) before each multiply.
    localparam int OPERAND_WIDTH    = 37;
    localparam logic [63:0] OPERAND_BOUND = (64'd1 << (OPERAND_WIDTH - 1)) - 64'd1;

    localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RESET = 24'd15360;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_I_RESET = 24'd0;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_D_RESET = 24'd0;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET  = 16'd4000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_P = 8'd0,
        CFG_GAIN_I = 8'd1,
        CFG_GAIN_D = 8'd2,
        CFG_LIMIT  = 8'd3
    } t_cfg_index;

endpackage

/* rtl/axis_pid_position_control.sv */
// Stream position PID controller, top level.
// Four-stage pipeline: input, state update, products, output magnitude.
// Depends on pidpos_pkg.
//
// Usage:
//   The slave stream carries one item per control tick: target position in
//   the low POSITION_WIDTH bits of tdata and measured position above it.
//   The master stream returns one item per input item: the PWM magnitude in
//   tdata[15:0] and the direction in tdata[16].
//   The configuration channel writes gains (index 0..2) and the drive limit
//   (index 3) and is always ready; the user must make writes only while the
//   block is idle; the block does not enforce this. One item is accepted
//   every cycle unless all stages are full; the integral and previous error
//   are updated in a single stage, so consecutive items never wait on each other.
//   Each stage holds its item while the next one is full, so when the
//   receiver stalls the empty stages still fill and the input keeps taking
//   items until every stage is occupied.
//   Reset clears the pipeline, the integral, the previous error and the held
//   direction, and loads the gains and limit with their reset values.
module axis_pid_position_control #(
    parameter int POSITION_WIDTH     = 24,
    parameter int GAIN_FRACTION_BITS = 8,
    parameter int INTEGRAL_WIDTH     = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Slave stream.
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // tdata: target_position, measured_position (from bit 0 up), zero padded.
    input  logic [((2*POSITION_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // Master stream.
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // tdata: drive_magnitude [15:0], drive_direction [16], zero padded.
    output logic [23:0]                               o_m_axis_tdata,
    // Configuration write channel.
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [pidpos_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [pidpos_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam int PW  = POSITION_WIDTH;
    localparam int EW  = PW + 1;
    localparam int DW  = PW + 2;
    localparam int IW  = INTEGRAL_WIDTH;
    localparam int AW  = ((IW > EW) ? IW : EW) + 1;
    localparam int OW  = pidpos_pkg::OPERAND_WIDTH;
    localparam int XW  = (IW > OW) ? IW : OW;
    localparam int GW  = pidpos_pkg::GAIN_WIDTH;
    localparam int LW  = pidpos_pkg::LIMIT_WIDTH;
    localparam int MW  = GW + OW;
    localparam int SW  = MW + 2;

    localparam logic signed [AW-1:0] IMAX_A =
        $signed({{(AW-IW+1){1'b0}}, {(IW-1){1'b1}}});
    localparam logic signed [AW-1:0] IMIN_A =
        $signed({{(AW-IW+1){1'b1}}, {(IW-1){1'b0}}});
    localparam logic signed [XW-1:0] BND_HI = $signed(XW'(pidpos_pkg::OPERAND_BOUND));
    localparam logic signed [XW-1:0] BND_LO = -BND_HI;

    // Configuration registers.
    logic signed [GW-1:0] r_gain_p;
    logic signed [GW-1:0] r_gain_i;
    logic signed [GW-1:0] r_gain_d;
    logic [LW-1:0]        r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= pidpos_pkg::GAIN_P_RESET;
            r_gain_i <= pidpos_pkg::GAIN_I_RESET;
            r_gain_d <= pidpos_pkg::GAIN_D_RESET;
            r_limit  <= pidpos_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (pidpos_pkg::t_cfg_index'(i_cfg_index))
                pidpos_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data[GW-1:0];
                pidpos_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data[GW-1:0];
                pidpos_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data[GW-1:0];
                pidpos_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and load enables.
    logic r_v0, r_v1, r_v2, r_v3;
    logic en0, en1, en2, en3;

    assign en3 = !r_v3 || i_m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign o_s_axis_tready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 0: input register.
    logic signed [PW-1:0] r_target;
    logic signed [PW-1:0] r_measured;

    always_ff @(posedge i_clk) begin
        if (en0 && i_s_axis_tvalid) begin
            r_target   <= i_s_axis_tdata[PW-1:0];
            r_measured <= i_s_axis_tdata[2*PW-1:PW];
        end
    end

    // Stage 1: error, saturating integral, error difference, direction.
    logic signed [IW-1:0] r_integral;
    logic signed [EW-1:0] r_prev_error;
    logic                 r_held_dir;
    logic signed [EW-1:0] r_err1;
    logic signed [IW-1:0] r_int1;
    logic signed [DW-1:0] r_diff1;

    logic signed [EW-1:0] n_error;
    logic signed [AW-1:0] n_int_sum;
    logic signed [IW-1:0] n_integral;
    logic signed [DW-1:0] n_diff;
    logic                 n_held_dir;

    always_comb begin
        n_error   = EW'(r_target) - EW'(r_measured);
        n_int_sum = AW'(r_integral) + AW'(n_error);
        if (n_int_sum > IMAX_A) begin
            n_integral = IMAX_A[IW-1:0];
        end else if (n_int_sum < IMIN_A) begin
            n_integral = IMIN_A[IW-1:0];
        end else begin
            n_integral = n_int_sum[IW-1:0];
        end
        n_diff = DW'(r_prev_error) - DW'(n_error);
        if (r_target > r_measured) begin
            n_held_dir = 1'b1;
        end else if (r_target < r_measured) begin
            n_held_dir = 1'b0;
        end else begin
            n_held_dir = r_held_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_error <= '0;
            r_held_dir   <= 1'b0;
        end else if (en1 && r_v0) begin
            r_integral   <= n_integral;
            r_prev_error <= n_error;
            r_held_dir   <= n_held_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && r_v0) begin
            r_err1  <= n_error;
            r_int1  <= n_integral;
            r_diff1 <= n_diff;
        end
    end

    // Stage 2: bounded operands times gains.
    logic                 r_dir2;
    logic signed [MW-1:0] r_prod_p;
    logic signed [MW-1:0] r_prod_i;
    logic signed [MW-1:0] r_prod_d;

    logic signed [XW-1:0] x_err, x_int, x_diff;
    logic signed [OW-1:0] b_err, b_int, b_diff;
    logic signed [MW-1:0] n_prod_p, n_prod_i, n_prod_d;

    always_comb begin
        x_err  = XW'(r_err1);
        x_int  = XW'(r_int1);
        x_diff = XW'(r_diff1);
        b_err  = (x_err > BND_HI)  ? BND_HI[OW-1:0] :
                 (x_err < BND_LO)  ? BND_LO[OW-1:0] : x_err[OW-1:0];
        b_int  = (x_int > BND_HI)  ? BND_HI[OW-1:0] :
                 (x_int < BND_LO)  ? BND_LO[OW-1:0] : x_int[OW-1:0];
        b_diff = (x_diff > BND_HI) ? BND_HI[OW-1:0] :
                 (x_diff < BND_LO) ? BND_LO[OW-1:0] : x_diff[OW-1:0];
        n_prod_p = MW'(r_gain_p) * MW'(b_err);
        n_prod_i = MW'(r_gain_i) * MW'(b_int);
        n_prod_d = MW'(r_gain_d) * MW'(b_diff);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_dir2   <= r_held_dir;
        end
    end

    // Stage 3: sum, absolute value, scaling and clamp.
    logic [LW-1:0] r_mag3;
    logic          r_dir3;

    logic signed [SW-1:0] n_sum;
    logic [SW-1:0]        n_abs;
    logic [SW-1:0]        n_scaled;
    logic [LW-1:0]        n_mag;

    always_comb begin
        n_sum    = SW'(r_prod_p) + SW'(r_prod_i) + SW'(r_prod_d);
        n_abs    = n_sum[SW-1] ? SW'(-n_sum) : SW'(n_sum);
        n_scaled = n_abs >> GAIN_FRACTION_BITS;
        if (n_scaled > SW'(r_limit)) begin
            n_mag = r_limit;
        end else begin
            n_mag = n_scaled[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_mag3 <= n_mag;
            r_dir3 <= r_dir2;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {7'd0, r_dir3, r_mag3};

endmodule

/* tb/axis_pid_position_control_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for axis_pid_position_control: sends position items and register
// writes with random idling on both streams, predicts every drive item and checks it in order.
// Depends on pidpos_pkg and the axis_pid_position_control RTL.
module axis_pid_position_control_test;

    localparam int POS_W = 24;
    localparam int FRAC_BITS = 8;
    localparam int INTEG_W = 32;
    localparam int IDX_W = pidpos_pkg::CFG_INDEX_WIDTH;
    localparam int DATA_W = pidpos_pkg::CFG_DATA_WIDTH;
    localparam int GAIN_W = pidpos_pkg::GAIN_WIDTH;
    localparam int LIM_W = pidpos_pkg::LIMIT_WIDTH;
    localparam logic [IDX_W-1:0] CFG_SPARE_INDEX = pidpos_pkg::CFG_LIMIT + IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_LAST_INDEX = '1;
    localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam longint ERR_MAX = (64'sd1 <<< POS_W) - 1;
    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint GAIN_MAX = (64'sd1 <<< (GAIN_W - 1)) - 1;
    localparam longint GAIN_MIN = -GAIN_MAX - 1;
    localparam longint OPERAND_LIMIT = pidpos_pkg::OPERAND_BOUND;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_STALL_CYCLES = 64;

    typedef struct packed {
        logic [LIM_W-1:0] magnitude;
        logic             direction;
    } t_drive;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [2*POS_W-1:0]            i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [23:0]                   o_m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [IDX_W-1:0]              i_cfg_index = '0;
    logic [DATA_W-1:0]             i_cfg_data = '0;

    // Controller state as this testbench tracks it.
    logic signed [GAIN_W-1:0]      gain_prop = pidpos_pkg::GAIN_P_RESET;
    logic signed [GAIN_W-1:0]      gain_int = pidpos_pkg::GAIN_I_RESET;
    logic signed [GAIN_W-1:0]      gain_deriv = pidpos_pkg::GAIN_D_RESET;
    logic [LIM_W-1:0]              drive_cap = pidpos_pkg::LIMIT_RESET;
    longint                        integral_acc = 0;
    longint                        last_error = 0;
    logic                          last_dir = 1'b0;

    t_drive                        expected_drives[$];
    t_drive                        want;
    int                            fail_count = 0;
    int                            tx_busy_pct = 20;
    int                            rx_busy_pct = 20;
    int                            stall_left = 0;
    logic                          stall_request = 1'b0;

    axis_pid_position_control dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_request) begin
            stall_request = 1'b0;
            stall_left = LONG_STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_busy_pct == 0) begin
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_left = $urandom_range(10, 50);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_busy_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t: drive item with none expected, actual %h", $time, o_m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_drives.pop_front();
                if (o_m_axis_tdata[15:0] !== want.magnitude) begin
                    $display("%0t: drive_magnitude expected %0d actual %0d",
                             $time, want.magnitude, o_m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[16] !== want.direction) begin
                    $display("%0t: drive_direction expected %0b actual %0b",
                             $time, want.direction, o_m_axis_tdata[16]);
                    fail_count++;
                end
                if (o_m_axis_tdata[23:17] !== '0) begin
                    $display("%0t: padding expected 0 actual %h", $time, o_m_axis_tdata[23:17]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("axis_pid_position_control test failed");
        $finish;
    end

    function automatic longint clip_operand(input longint x);
        if (x > OPERAND_LIMIT)
            return OPERAND_LIMIT;
        if (x < -OPERAND_LIMIT)
            return -OPERAND_LIMIT;
        return x;
    endfunction

    function automatic longint rand_position();
        logic signed [POS_W-1:0] r;
        r = POS_W'($urandom());
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input int style);
        case (style)
            0: pick_gain = GAIN_W'($urandom_range(0, 4096) - 2048);
            1: pick_gain = GAIN_W'($urandom());
            default: begin
                case ($urandom_range(0, 2))
                    0: pick_gain = GAIN_W'(GAIN_MIN);
                    1: pick_gain = GAIN_W'(GAIN_MAX);
                    default: pick_gain = '0;
                endcase
            end
        endcase
    endfunction

    // Offers one position item, updates the controller state on acceptance and
    // queues the drive item that it must produce.
    task automatic send_position(input longint target, input longint measured);
        longint err;
        longint acc;
        longint total;
        longint mag;
        t_drive drive;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {measured[POS_W-1:0], target[POS_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        err = target - measured;
        acc = integral_acc + err;
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        else if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        total = longint'(gain_prop) * clip_operand(err)
              + longint'(gain_int) * clip_operand(acc)
              + longint'(gain_deriv) * clip_operand(last_error - err);
        mag = (total < 0 ? -total : total) >>> FRAC_BITS;
        if (mag > longint'(drive_cap))
            mag = drive_cap;
        if (err > 0)
            last_dir = 1'b1;
        else if (err < 0)
            last_dir = 1'b0;
        integral_acc = acc;
        last_error = err;
        drive.magnitude = mag[LIM_W-1:0];
        drive.direction = last_dir;
        expected_drives.push_back(drive);
        if (tx_busy_pct != 0 && $urandom_range(0, 99) < tx_busy_pct) begin
            i_s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Sends an item with the given error, placing the pair at a random point in range.
    task automatic send_error(input longint err);
        longint lo;
        longint hi;
        longint target;
        lo = POS_MIN + (err > 0 ? err : 0);
        hi = POS_MAX + (err < 0 ? err : 0);
        target = lo + longint'($urandom_range(0, 32'(hi - lo)));
        send_position(target, target - err);
    endtask

    task automatic wait_idle;
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_drives.size() != 0);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] index,
                             input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            pidpos_pkg::CFG_GAIN_P: gain_prop = data;
            pidpos_pkg::CFG_GAIN_I: gain_int = data;
            pidpos_pkg::CFG_GAIN_D: gain_deriv = data;
            pidpos_pkg::CFG_LIMIT:  drive_cap = data[LIM_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd,
                             input logic [DATA_W-1:0] cap);
        wait_idle();
        cfg_write(pidpos_pkg::CFG_GAIN_P, kp);
        cfg_write(pidpos_pkg::CFG_GAIN_I, ki);
        cfg_write(pidpos_pkg::CFG_GAIN_D, kd);
        cfg_write(pidpos_pkg::CFG_LIMIT, cap);
    endtask

    // Drives the integral back to zero with the largest steps the error allows.
    task automatic recenter_integral;
        longint step;
        while (integral_acc != 0) begin
            step = -integral_acc;
            if (step > ERR_MAX)
                step = ERR_MAX;
            else if (step < -ERR_MAX)
                step = -ERR_MAX;
            send_error(step);
        end
    endtask

    task automatic test_reset_values;
        send_position(0, 0);
        send_position(5, 4);
        send_position(7, 7);
        send_position(-3, -1);
        send_position(POS_MAX, POS_MIN);
        send_position(POS_MIN, POS_MAX);
        send_position(100, 100);
        send_position(66, 0);
        send_position(67, 0);
    endtask

    task automatic test_gain_extremes;
        configure(GAIN_W'(GAIN_MIN), '0, '0, 24'hFFFFFF);
        send_position(1, 0);
        send_position(POS_MAX, POS_MIN);
        configure('1, '0, '0, 24'hFFFFFF);
        send_position(1, 0);
        send_position(-300, 0);
        configure(GAIN_W'(GAIN_MAX), '0, '0, 24'hFFFFFF);
        send_position(0, 1);
        configure('0, '0, GAIN_W'(GAIN_MAX), 24'hFFFFFF);
        send_position(10, 0);
        send_position(0, 0);
        send_position(POS_MIN, POS_MAX);
        configure('0, GAIN_W'(GAIN_MIN), '0, 24'hFFFFFF);
        send_position(2, 0);
        send_position(POS_MAX, POS_MIN);
    endtask

    task automatic test_zero_limit;
        configure(pidpos_pkg::GAIN_P_RESET, '0, '0, '0);
        send_position(POS_MAX, 0);
        send_position(-5, 5);
    endtask

    task automatic test_spare_index;
        configure(pidpos_pkg::GAIN_P_RESET, '0, '0, DATA_W'(pidpos_pkg::LIMIT_RESET));
        cfg_write(CFG_SPARE_INDEX, 24'h123456);
        cfg_write(CFG_LAST_INDEX, 24'hFFFFFF);
        send_position(5, 0);
        send_position(POS_MAX, POS_MIN);
    endtask

    task automatic test_integral_windup;
        longint err;
        configure('0, GAIN_W'(1), '0, 24'hFFFFFF);
        repeat (150) begin
            err = ERR_MAX - $urandom_range(0, 1 << 22);
            send_error(err);
        end
        repeat (300) begin
            err = ERR_MAX - $urandom_range(0, 1 << 22);
            send_error(-err);
        end
        recenter_integral();
    endtask

    task automatic test_back_pressure;
        longint err;
        wait_idle();
        tx_busy_pct = 0;
        stall_request = 1'b1;
        repeat (24) begin
            err = $urandom_range(0, 2000);
            send_error(err - 1000);
        end
        tx_busy_pct = 20;
    endtask

    task automatic test_random_settings;
        int style;
        int jitter;
        longint goal;
        longint pos;
        logic [DATA_W-1:0] cap;
        goal = 0;
        pos = 0;
        for (int phase = 0; phase < 6; phase++) begin
            style = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: cap = '0;
                1: cap = '1;
                2: cap = DATA_W'(pidpos_pkg::LIMIT_RESET);
                default: cap = DATA_W'($urandom());
            endcase
            configure(pick_gain(style), pick_gain(style), pick_gain(style), cap);
            tx_busy_pct = (phase % 3) * 25;
            rx_busy_pct = ((phase + 1) % 3) * 25;
            recenter_integral();
            repeat (50) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_position(rand_position(), rand_position());
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        goal = $urandom_range(0, 1) ? rand_position() : rand_position() >>> 12;
                    jitter = $urandom_range(0, 16);
                    jitter -= 8;
                    pos = pos + (goal - pos) / 4 + jitter;
                    if ($urandom_range(0, 19) == 0)
                        pos = goal;
                    if (pos > POS_MAX)
                        pos = POS_MAX;
                    else if (pos < POS_MIN)
                        pos = POS_MIN;
                    send_position(goal, pos);
                end
            end
        end
        tx_busy_pct = 20;
        rx_busy_pct = 20;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_gain_extremes();
        test_zero_limit();
        test_spare_index();
        test_integral_windup();
        test_back_pressure();
        test_random_settings();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("axis_pid_position_control test passed");
        else
            $display("axis_pid_position_control test failed");
        $finish;
    end

endmodule
